// ===== rtl/sgms_pkg.sv =====
package sgms_pkg;

    localparam int CHANNELS_DEF      = 8;
    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int POSITION_BITS_DEF = 40;
    localparam int MAX_CHANNELS      = 8;

    localparam int THR_W = 24;
    localparam int MIN_W = 24;
    localparam int ACT_W = 4;
    localparam int CFG_W = 24;
    localparam int OUT_W = 40;
    localparam int THR_N_W = THR_W + ACT_W;

    localparam logic [THR_W-1:0] THRESHOLD_RST   = THR_W'(47171);
    localparam logic [MIN_W-1:0] MIN_SILENCE_RST = MIN_W'(7200);
    localparam logic [ACT_W-1:0] ACTIVE_RST      = ACT_W'(2);

    typedef enum logic [1:0] {
        REG_SILENCE_THRESHOLD   = 2'd0,
        REG_MIN_SILENCE_SAMPLES = 2'd1,
        REG_ACTIVE_CHANNELS     = 2'd2
    } cfg_index_t;

    // Load enables of the three pipeline stages.
    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
    } pipe_ctl_t;

endpackage

// ===== rtl/sgms_frame_if.sv =====
interface sgms_frame_if #(
    parameter int SAMPLE_BITS = sgms_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] channel_0;
    logic signed [SAMPLE_BITS-1:0] channel_1;
    logic signed [SAMPLE_BITS-1:0] channel_2;
    logic signed [SAMPLE_BITS-1:0] channel_3;
    logic signed [SAMPLE_BITS-1:0] channel_4;
    logic signed [SAMPLE_BITS-1:0] channel_5;
    logic signed [SAMPLE_BITS-1:0] channel_6;
    logic signed [SAMPLE_BITS-1:0] channel_7;
    logic                          last_frame;

    modport source (
        output valid, channel_0, channel_1, channel_2, channel_3,
               channel_4, channel_5, channel_6, channel_7, last_frame,
        input  ready
    );
    modport sink (
        input  valid, channel_0, channel_1, channel_2, channel_3,
               channel_4, channel_5, channel_6, channel_7, last_frame,
        output ready
    );
endinterface

// ===== rtl/sgms_split_if.sv =====
interface sgms_split_if ();
    import sgms_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] split_position;

    modport source (output valid, split_position, input ready);
    modport sink (input valid, split_position, output ready);
endinterface

// ===== rtl/sgms_lane.sv =====
module sgms_lane #(
    parameter int SAMPLE_BITS = sgms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          load,
    input  logic                          active,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SAMPLE_BITS-1:0] value
);
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic signed [SAMPLE_BITS-1:0] value_next;

    // A channel outside the active set contributes nothing to the mix.
    always_comb
    begin
        value_next = active ? sample : '0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;
endmodule

// ===== rtl/sgms_merge.sv =====
module sgms_merge #(
    parameter int CHANNELS    = sgms_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = sgms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  sgms_pkg::pipe_ctl_t           ctl,
    input  logic signed [SAMPLE_BITS-1:0] lane_val [CHANNELS],
    input  logic                          last_in,
    input  logic [sgms_pkg::THR_N_W-1:0]  thr_n,
    output logic                          silent,
    output logic                          last_out
);
    import sgms_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + $clog2(CHANNELS) + 1;
    localparam int CMP_W = (SUM_W > THR_N_W) ? SUM_W : THR_N_W;

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic                    last2_reg;
    logic [SUM_W-1:0]        mag;
    logic                    silent_reg;
    logic                    silent_next;
    logic                    last3_reg;

    always_comb
    begin
        sum_next = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            sum_next = sum_next + SUM_W'(lane_val[c]);
        end
    end

    // The most negative sum negates to itself, which as unsigned is its magnitude.
    always_comb
    begin
        mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        silent_next = CMP_W'(mag) < CMP_W'(thr_n);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load2)
        begin
            sum_reg   <= sum_next;
            last2_reg <= last_in;
        end
        if (ctl.load3)
        begin
            silent_reg <= silent_next;
            last3_reg  <= last2_reg;
        end
    end

    assign silent   = silent_reg;
    assign last_out = last3_reg;
endmodule

// ===== rtl/sgms_tracker.sv =====
module sgms_tracker #(
    parameter int POSITION_BITS = sgms_pkg::POSITION_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  logic                         silent,
    input  logic                         last,
    input  logic [sgms_pkg::MIN_W-1:0]   min_len,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [sgms_pkg::OUT_W-1:0]   split_position
);
    import sgms_pkg::*;

    localparam int PW    = POSITION_BITS;
    localparam int LEN_W = (PW > MIN_W) ? PW : MIN_W;

    logic [PW-1:0]    frame_pos_reg, frame_pos_next;
    logic             in_sil_reg, in_sil_next;
    logic [PW-1:0]    run_start_reg, run_start_next;
    logic [PW-1:0]    run_len_reg, run_len_next;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] split_reg, split_next;

    logic [PW-1:0] start_base;
    logic [PW-1:0] len_base;
    logic [PW-1:0] len_inc;
    logic          loud_hit;
    logic          trail_hit;
    logic          emit;
    logic [PW-1:0] src_start;
    logic [PW-1:0] src_len;
    logic [PW-1:0] midpoint;

    always_comb
    begin
        start_base = in_sil_reg ? run_start_reg : frame_pos_reg;
        len_base   = in_sil_reg ? run_len_reg : '0;
        len_inc    = (len_base == '1) ? len_base : len_base + PW'(1);

        // A loud frame closes the open run; a silent last frame closes the
        // run it has just extended.
        loud_hit  = in_sil_reg && (LEN_W'(run_len_reg) >= LEN_W'(min_len));
        trail_hit = last && (LEN_W'(len_inc) >= LEN_W'(min_len));
        emit      = silent ? trail_hit : loud_hit;

        src_start = silent ? start_base : run_start_reg;
        src_len   = silent ? len_inc : run_len_reg;
        midpoint  = src_start + (src_len >> 1);

        if (last)
        begin
            frame_pos_next = '0;
            in_sil_next    = 1'b0;
            run_start_next = '0;
            run_len_next   = '0;
        end
        else
        begin
            frame_pos_next = frame_pos_reg + PW'(1);
            in_sil_next    = silent;
            run_start_next = silent ? start_base : '0;
            run_len_next   = silent ? len_inc : '0;
        end

        out_valid_next = out_valid_reg;
        split_next     = split_reg;
        if (fire)
        begin
            out_valid_next = emit;
            if (emit)
            begin
                split_next = OUT_W'(midpoint);
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pos_reg <= '0;
            in_sil_reg    <= 1'b0;
            run_start_reg <= '0;
            run_len_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                frame_pos_reg <= frame_pos_next;
                in_sil_reg    <= in_sil_next;
                run_start_reg <= run_start_next;
                run_len_reg   <= run_len_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        split_reg <= split_next;
    end

    assign out_valid      = out_valid_reg;
    assign split_position = split_reg;
endmodule

// ===== rtl/silence_gap_midpoint_splitter_top.sv =====
// Channel   Direction  Beat contents
// frame     in         channel_0..channel_7, last_frame
// split     out        split_position
// cfg       in         cfg_we, cfg_index, cfg_wdata (write only)
//
// One frame is taken every cycle while the pipeline is not stalled; a frame's split,
// if any, passes through the lane, sum and compare registers, then the output register.
// The rate is set by the lane/sum/compare pipeline, one frame per stage.
// Reset restores the register defaults and clears the position and run state.
// A stalled output register holds the frames in the pipeline, and frame.ready falls
// only once every stage holds a frame.
module silence_gap_midpoint_splitter_top #(
    parameter int CHANNELS      = sgms_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS   = sgms_pkg::SAMPLE_BITS_DEF,
    parameter int POSITION_BITS = sgms_pkg::POSITION_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    sgms_frame_if.sink                frame,
    sgms_split_if.source              split,
    input  logic                      cfg_we,
    input  sgms_pkg::cfg_index_t      cfg_index,
    input  logic [sgms_pkg::CFG_W-1:0] cfg_wdata
);
    import sgms_pkg::*;

    logic [THR_W-1:0] threshold_reg, threshold_next;
    logic [MIN_W-1:0] min_sil_reg, min_sil_next;
    logic [ACT_W-1:0] active_reg, active_next;

    logic [ACT_W-1:0]   n_eff;
    logic [THR_N_W-1:0] thr_n;

    logic signed [SAMPLE_BITS-1:0] samples [MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] lane_val [CHANNELS];

    logic      v1_reg, v2_reg, v3_reg;
    logic      last1_reg;
    logic      out_can, ok1, ok2, ok3, fire;
    pipe_ctl_t ctl;
    logic      silent, last3;

    always_comb
    begin
        threshold_next = threshold_reg;
        min_sil_next   = min_sil_reg;
        active_next    = active_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SILENCE_THRESHOLD:   threshold_next = cfg_wdata[THR_W-1:0];
                REG_MIN_SILENCE_SAMPLES: min_sil_next   = cfg_wdata[MIN_W-1:0];
                REG_ACTIVE_CHANNELS:     active_next    = cfg_wdata[ACT_W-1:0];
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            min_sil_reg   <= MIN_SILENCE_RST;
            active_reg    <= ACTIVE_RST;
        end
        else
        begin
            threshold_reg <= threshold_next;
            min_sil_reg   <= min_sil_next;
            active_reg    <= active_next;
        end
    end

    // Comparing |sum| with threshold * n is the same as comparing the mean.
    always_comb
    begin
        if (active_reg == '0)
            n_eff = ACT_W'(1);
        else if (active_reg > ACT_W'(CHANNELS))
            n_eff = ACT_W'(CHANNELS);
        else
            n_eff = active_reg;
        thr_n = THR_N_W'(threshold_reg) * THR_N_W'(n_eff);
    end

    assign samples[0] = frame.channel_0;
    assign samples[1] = frame.channel_1;
    assign samples[2] = frame.channel_2;
    assign samples[3] = frame.channel_3;
    assign samples[4] = frame.channel_4;
    assign samples[5] = frame.channel_5;
    assign samples[6] = frame.channel_6;
    assign samples[7] = frame.channel_7;

    // Stage k may load when it is empty or its beat moves on this cycle.
    assign out_can   = !split.valid || split.ready;
    assign ok3       = !v3_reg || out_can;
    assign ok2       = !v2_reg || ok3;
    assign ok1       = !v1_reg || ok2;
    assign fire      = v3_reg && out_can;
    assign ctl       = '{load1: ok1, load2: ok2, load3: ok3};
    assign frame.ready = ok1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ok1)
                v1_reg <= frame.valid;
            if (ok2)
                v2_reg <= v1_reg;
            if (ok3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load1)
        begin
            last1_reg <= frame.last_frame;
        end
    end

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        sgms_lane #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_lane (
            .clk    (clk),
            .load   (ctl.load1),
            .active (ACT_W'(c) < n_eff),
            .sample (samples[c]),
            .value  (lane_val[c])
        );
    end

    sgms_merge #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .clk      (clk),
        .ctl      (ctl),
        .lane_val (lane_val),
        .last_in  (last1_reg),
        .thr_n    (thr_n),
        .silent   (silent),
        .last_out (last3)
    );

    sgms_tracker #(
        .POSITION_BITS(POSITION_BITS)
    ) u_tracker (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .silent         (silent),
        .last           (last3),
        .min_len        (min_sil_reg),
        .out_ready      (split.ready),
        .out_valid      (split.valid),
        .split_position (split.split_position)
    );

    // Backpressure reaches the input only when all three stages are full.
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !frame.ready |-> (v1_reg && v2_reg && v3_reg))
        else $error("frame.ready low with an empty stage");

    // A frame in the last stage waits while the output register is blocked.
    a_hold_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !out_can) |=> v3_reg)
        else $error("last stage dropped a frame under stall");

    // A new split appears only from a frame processed by the tracker.
    a_split_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(split.valid) |-> $past(fire))
        else $error("split beat without a processed frame");
endmodule

// ===== tb/sgms_split_checker.sv =====
module sgms_split_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    sgms_frame_if                        frame,
    sgms_split_if                        split,
    input  logic                         cfg_we,
    input  sgms_pkg::cfg_index_t         cfg_index,
    input  logic [sgms_pkg::CFG_W-1:0]   cfg_wdata,
    output int                           fail_count,
    output int                           splits_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sgms_pkg::*;

    localparam int POS_W = POSITION_BITS_DEF;
    localparam int LANES = CHANNELS_DEF;

    logic [THR_W-1:0] threshold;
    logic [MIN_W-1:0] min_run;
    logic [ACT_W-1:0] active;

    logic [POS_W-1:0] position;
    logic [POS_W-1:0] run_first;
    logic [POS_W-1:0] run_len;
    logic             run_open;

    logic [OUT_W-1:0] splits_due [$];

    // Mixes the active lanes, classifies the frame and advances the run tracker.
    task automatic track_frame();
        logic signed [SAMPLE_BITS_DEF-1:0] lanes [LANES];
        logic [POS_W-1:0]                  mid;
        longint                            sum;
        longint                            mag;
        int                                n;
        logic                              silent;
        logic                              emit;

        lanes[0] = frame.channel_0;
        lanes[1] = frame.channel_1;
        lanes[2] = frame.channel_2;
        lanes[3] = frame.channel_3;
        lanes[4] = frame.channel_4;
        lanes[5] = frame.channel_5;
        lanes[6] = frame.channel_6;
        lanes[7] = frame.channel_7;

        n = int'(active);
        if (n < 1)
            n = 1;
        if (n > LANES)
            n = LANES;
        sum = 0;
        for (int c = 0; c < n; c++)
            sum = sum + longint'(lanes[c]);
        mag = (sum < 0) ? -sum : sum;
        silent = mag < longint'(threshold) * n;
        emit = 1'b0;
        mid = '0;

        if (silent) begin
            if (!run_open) begin
                run_open = 1'b1;
                run_first = position;
                run_len = '0;
            end
            if (run_len != '1)
                run_len = run_len + 1'b1;
        end
        else begin
            if (run_open && run_len >= POS_W'(min_run)) begin
                mid = run_first + (run_len >> 1);
                emit = 1'b1;
            end
            run_open = 1'b0;
            run_first = '0;
            run_len = '0;
        end

        // End of clip: a qualifying trailing run still splits, then all state clears.
        if (frame.last_frame) begin
            if (!emit && run_open && run_len >= POS_W'(min_run)) begin
                mid = run_first + (run_len >> 1);
                emit = 1'b1;
            end
            position = '0;
            run_open = 1'b0;
            run_first = '0;
            run_len = '0;
        end
        else begin
            position = position + 1'b1;
        end

        if (emit)
            splits_due = {splits_due, OUT_W'(mid)};
    endtask

    task automatic check_split();
        logic [OUT_W-1:0] want;

        if (splits_due.size() == 0) begin
            $error("split_position: expected none, actual %0d", split.split_position);
            fail_count++;
        end
        else begin
            want = splits_due.pop_front();
            if (split.split_position !== want) begin
                $error("split_position: expected %0d, actual %0d",
                       want, split.split_position);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            threshold = THRESHOLD_RST;
            min_run = MIN_SILENCE_RST;
            active = ACTIVE_RST;
            position = '0;
            run_first = '0;
            run_len = '0;
            run_open = 1'b0;
            splits_due.delete();
            fail_count = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SILENCE_THRESHOLD:   threshold = cfg_wdata[THR_W-1:0];
                    REG_MIN_SILENCE_SAMPLES: min_run = cfg_wdata[MIN_W-1:0];
                    REG_ACTIVE_CHANNELS:     active = cfg_wdata[ACT_W-1:0];
                    default: ;
                endcase
            end
            if (frame.valid && frame.ready)
                track_frame();
            if (split.valid && split.ready)
                check_split();
        end
        splits_pending = splits_due.size();
    end

endmodule

// ===== tb/silence_gap_midpoint_splitter_top_tb.sv =====
module silence_gap_midpoint_splitter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sgms_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 50;
    localparam int PHASES       = 12;
    localparam int FULL_POS     = 8388607;
    localparam int FULL_NEG     = -8388608;
    localparam int LANES        = CHANNELS_DEF;

    typedef struct {
        logic signed [SAMPLE_BITS_DEF-1:0] ch [LANES];
        logic                              last;
    } frame_beat_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    cfg_index_t       cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    int fail_count;
    int splits_pending;
    int cycle_count;
    int cur_thr;
    int cur_min;
    int cur_act;
    bit hold_req;
    bit force_burst;
    bit tx_burst;
    bit rx_burst;

    sgms_frame_if frame_bus ();
    sgms_split_if split_bus ();

    silence_gap_midpoint_splitter_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame_bus),
        .split     (split_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    sgms_split_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame          (frame_bus),
        .split          (split_bus),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .fail_count     (fail_count),
        .splits_pending (splits_pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic int mixed_lanes();
        if (cur_act < 1)
            return 1;
        if (cur_act > LANES)
            return LANES;
        return cur_act;
    endfunction

    function automatic frame_beat_t uniform_frame(input int v, input logic last);
        frame_beat_t f;

        for (int c = 0; c < LANES; c++)
            f.ch[c] = SAMPLE_BITS_DEF'(v);
        f.last = last;
        return f;
    endfunction

    function automatic frame_beat_t noise_frame();
        frame_beat_t f;

        for (int c = 0; c < LANES; c++)
            f.ch[c] = SAMPLE_BITS_DEF'($urandom());
        f.last = 1'b0;
        return f;
    endfunction

    // Active lanes stay strictly inside the threshold; idle lanes carry noise.
    function automatic frame_beat_t quiet_frame();
        frame_beat_t f;
        int          n;
        int          amp;
        bit          zero;

        f = noise_frame();
        n = mixed_lanes();
        amp = (cur_thr > 0) ? cur_thr - 1 : 0;
        if (amp > FULL_POS)
            amp = FULL_POS;
        zero = ($urandom_range(0, 7) == 0);
        for (int c = 0; c < n; c++)
            f.ch[c] = zero ? '0 : SAMPLE_BITS_DEF'(int'($urandom_range(0, 2 * amp)) - amp);
        return f;
    endfunction

    function automatic frame_beat_t loud_frame();
        frame_beat_t f;
        int          n;
        int          lo;
        int          mag;
        bit          neg;

        f = noise_frame();
        n = mixed_lanes();
        neg = $urandom_range(0, 1);
        lo = (cur_thr > FULL_POS) ? FULL_POS : cur_thr;
        for (int c = 0; c < n; c++) begin
            mag = $urandom_range(lo, FULL_POS);
            f.ch[c] = neg ? SAMPLE_BITS_DEF'(-mag - int'($urandom_range(0, 1)))
                          : SAMPLE_BITS_DEF'(mag);
        end
        return f;
    endfunction

    // Puts the mixed magnitude within a couple of counts of threshold times lanes.
    function automatic frame_beat_t edge_frame();
        frame_beat_t f;
        int          n;
        int          target;
        int          share;
        int          v;
        bit          neg;

        f = noise_frame();
        n = mixed_lanes();
        neg = $urandom_range(0, 1);
        target = cur_thr * n + int'($urandom_range(0, 3)) - 2;
        if (target < 0)
            target = 0;
        share = target / n;
        for (int c = 0; c < n; c++) begin
            v = (c == 0) ? target - share * (n - 1) : share;
            if (neg)
                v = -v;
            if (v > FULL_POS)
                v = FULL_POS;
            if (v < FULL_NEG)
                v = FULL_NEG;
            f.ch[c] = SAMPLE_BITS_DEF'(v);
        end
        return f;
    endfunction

    task automatic drive_frame(input frame_beat_t f);
        int gap;

        if (!force_burst && $urandom_range(0, 15) == 0)
            tx_burst = !tx_burst;
        gap = (tx_burst || force_burst) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            frame_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        frame_bus.channel_0 = f.ch[0];
        frame_bus.channel_1 = f.ch[1];
        frame_bus.channel_2 = f.ch[2];
        frame_bus.channel_3 = f.ch[3];
        frame_bus.channel_4 = f.ch[4];
        frame_bus.channel_5 = f.ch[5];
        frame_bus.channel_6 = f.ch[6];
        frame_bus.channel_7 = f.ch[7];
        frame_bus.last_frame = f.last;
        frame_bus.valid = 1'b1;
        do
            @(posedge clk);
        while (!frame_bus.ready);
        @(negedge clk);
    endtask

    // Frames that split nothing may still be in flight, so a few more cycles pass.
    task automatic wait_drained();
        frame_bus.valid = 1'b0;
        while (splits_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apply_setting(input int thr, input int min_len, input int act);
        cfg_we = 1'b1;
        cfg_index = REG_SILENCE_THRESHOLD;
        cfg_wdata = CFG_W'(thr);
        @(negedge clk);
        cfg_index = REG_MIN_SILENCE_SAMPLES;
        cfg_wdata = CFG_W'(min_len);
        @(negedge clk);
        cfg_index = REG_ACTIVE_CHANNELS;
        cfg_wdata = CFG_W'(act);
        @(negedge clk);
        cfg_we = 1'b0;
        cur_thr = thr;
        cur_min = min_len;
        cur_act = act;
    endtask

    task automatic run_directed();
        frame_beat_t f;

        // Register defaults: full-scale frames, then an all-zero last frame.
        drive_frame(uniform_frame(FULL_POS, 1'b0));
        drive_frame(uniform_frame(FULL_NEG, 1'b0));
        drive_frame(uniform_frame(0, 1'b1));

        // Zero channel count mixes one lane; the others must not matter.
        wait_drained();
        apply_setting(1000, 2, 0);
        f = noise_frame(); f.ch[0] = 999;  drive_frame(f);
        f = noise_frame(); f.ch[0] = -999; drive_frame(f);
        f = noise_frame(); f.ch[0] = 1000; drive_frame(f);
        f = noise_frame(); f.ch[0] = 0;    drive_frame(f);
        f = noise_frame(); f.ch[0] = 500;  drive_frame(f);
        f = noise_frame(); f.ch[0] = -500; drive_frame(f);
        f = noise_frame(); f.ch[0] = -999; f.last = 1'b1; drive_frame(f);
        f = noise_frame(); f.ch[0] = 1;    drive_frame(f);
        f = noise_frame(); f.ch[0] = -1;   drive_frame(f);
        f = noise_frame(); f.ch[0] = -1000; f.last = 1'b1; drive_frame(f);

        // Oversized channel count saturates; zero minimum makes one frame enough.
        wait_drained();
        apply_setting(1000, 0, 15);
        drive_frame(uniform_frame(999, 1'b0));
        drive_frame(uniform_frame(1000, 1'b0));
        drive_frame(uniform_frame(-1000, 1'b0));
        drive_frame(uniform_frame(-999, 1'b1));

        // Zero threshold: nothing is silent, not even an all-zero frame.
        wait_drained();
        apply_setting(0, 0, 1);
        drive_frame(uniform_frame(0, 1'b0));
        drive_frame(uniform_frame(0, 1'b1));

        // Threshold of 2^23 and the largest minimum.
        wait_drained();
        apply_setting(8388608, 16777215, 8);
        drive_frame(uniform_frame(FULL_NEG, 1'b0));
        drive_frame(uniform_frame(FULL_POS, 1'b0));
        drive_frame(uniform_frame(FULL_POS, 1'b1));
    endtask

    task automatic run_phase(input int count);
        frame_beat_t f;
        int          seg_left;
        int          pick;
        int          span;
        bit          seg_quiet;

        seg_left = 0;
        seg_quiet = 1'b0;
        for (int i = 0; i < count; i++) begin
            if (seg_left == 0) begin
                seg_quiet = !seg_quiet;
                span = (cur_min > 40) ? 40 : cur_min;
                seg_left = seg_quiet ? $urandom_range(1, span + 3) : $urandom_range(1, 3);
            end
            seg_left--;
            pick = $urandom_range(0, 19);
            if (pick < 2)
                f = noise_frame();
            else if (pick < 4)
                f = edge_frame();
            else if (seg_quiet)
                f = quiet_frame();
            else
                f = loud_frame();
            f.last = ($urandom_range(0, 29) == 0);
            drive_frame(f);
        end
    endtask

    // Result side: random stalls per beat, plus one long hold-off on request.
    initial begin
        int stall;

        split_bus.ready = 1'b0;
        rx_burst = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (hold_req) begin
                split_bus.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            if ($urandom_range(0, 15) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                split_bus.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            split_bus.ready = 1'b1;
            do
                @(posedge clk);
            while (!(split_bus.valid && split_bus.ready) && !hold_req);
            @(negedge clk);
        end
    end

    initial begin
        rst_n = 1'b0;
        frame_bus.valid = 1'b0;
        frame_bus.channel_0 = '0;
        frame_bus.channel_1 = '0;
        frame_bus.channel_2 = '0;
        frame_bus.channel_3 = '0;
        frame_bus.channel_4 = '0;
        frame_bus.channel_5 = '0;
        frame_bus.channel_6 = '0;
        frame_bus.channel_7 = '0;
        frame_bus.last_frame = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SILENCE_THRESHOLD;
        cfg_wdata = '0;
        hold_req = 1'b0;
        force_burst = 1'b0;
        tx_burst = 1'b0;
        cur_thr = int'(THRESHOLD_RST);
        cur_min = int'(MIN_SILENCE_RST);
        cur_act = int'(ACTIVE_RST);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0: apply_setting(1000, 0, 1);
                1: apply_setting(8388608, 3, 8);
                2: apply_setting(0, 0, 0);
                3: apply_setting(20000, 16777215, 2);
                4: apply_setting(5000, 40, 4);
                default: apply_setting(($urandom_range(0, 3) == 0) ? $urandom_range(0, 8388608)
                                                                  : $urandom_range(1, 60000),
                                       $urandom_range(0, 12), $urandom_range(0, 15));
            endcase
            // First phase: results come every few frames while the result side
            // holds off, so the pipeline backs up into the frame input.
            if (p == 0) begin
                hold_req = 1'b1;
                force_burst = 1'b1;
            end
            run_phase(PHASE_ITEMS);
            force_burst = 1'b0;
        end

        wait_drained();
        if (fail_count == 0 && splits_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== silence_gap_midpoint_splitter_top.f =====
rtl/sgms_pkg.sv
rtl/sgms_frame_if.sv
rtl/sgms_split_if.sv
rtl/sgms_lane.sv
rtl/sgms_merge.sv
rtl/sgms_tracker.sv
rtl/silence_gap_midpoint_splitter_top.sv
tb/sgms_split_checker.sv
tb/silence_gap_midpoint_splitter_top_tb.sv
